@@ rtl/ghash_pkg.sv @@
// Shared types and constants for the GHASH accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ghash_pkg;

  localparam int unsigned BlockW            = 128;
  localparam int unsigned HalfW             = 64;
  localparam int unsigned CntW              = 5;
  localparam int unsigned BlockBytes        = BlockW / 8;
  localparam int unsigned CfgIdxW           = 1;
  localparam int unsigned CfgDataW          = HalfW;
  localparam int unsigned QueueDepthDefault = 2;

  // Reflected GCM reduction constant: x^128 = 1 + x + x^2 + x^7.
  localparam logic [HalfW-1:0] GfReduceHigh = 64'hE100_0000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [HalfW-1:0] block_high;
    logic [HalfW-1:0] block_low;
    logic [CntW-1:0]  valid_bytes;
    logic             final_block;
  } in_item_t;

  typedef struct packed {
    logic [HalfW-1:0] digest_high;
    logic [HalfW-1:0] digest_low;
  } out_item_t;

  typedef struct packed {
    logic [BlockW-1:0] data;
    logic              last;
  } q_item_t;

  typedef struct packed {
    logic pop_last;
    logic acc_zero;
  } back_status_t;

endpackage

`default_nettype wire

@@ rtl/ghash_gf128_accumulator.sv @@
// Top level of the GHASH accumulator: key registers, front, queue, back.
// Depends on ghash_pkg, ghash_front, ghash_queue and ghash_back.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i (in_item_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One block per cycle while no final block waits on a stalled digest; a final
// block's digest shows on out_valid_o once its queue entry is multiplied into the
// output register. The accumulator loop with the GF(2^128) multiply sets the rate.
// Async active-low reset clears queue, accumulator, keys and output valid.
// A stalled digest holds only final blocks at the queue head; others keep flowing.
`default_nettype none

module ghash_gf128_accumulator #(
  parameter int unsigned QueueDepth = ghash_pkg::QueueDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ghash_pkg::in_item_t             in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ghash_pkg::out_item_t                 out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ghash_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ghash_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import ghash_pkg::*;

  logic [HalfW-1:0] key_hi_q, key_lo_q;
  logic             q_full, q_push, q_valid, q_pop;
  q_item_t          q_in, q_out;
  back_status_t     bk_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgKeyHigh: key_hi_q <= cfg_wdata_i;
        CfgKeyLow:  key_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ghash_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_item_o (q_in)
  );

  ghash_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_out)
  );

  ghash_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_hi_q, key_lo_q}),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (bk_status)
  );

  a_final_gives_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.pop_last |=> out_valid_o)
    else $error("final block popped without a digest");

  a_final_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.pop_last |=> bk_status.acc_zero)
    else $error("accumulator not cleared after final block");

  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("input stalled with an empty queue");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

@@ rtl/ghash_front.sv @@
// Front end: takes input transfers, zeroes bytes past the valid count,
// and pushes the padded block into the queue. Uses ghash_pkg.
`default_nettype none

module ghash_front (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ghash_pkg::in_item_t in_data_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output ghash_pkg::q_item_t      push_item_o
);
  import ghash_pkg::*;

  logic [BlockW-1:0] raw;
  logic [BlockW-1:0] mask;

  assign raw = {in_data_i.block_high, in_data_i.block_low};

  // byte b survives when the count exceeds b; counts above 16 keep all
  always_comb begin
    for (int b = 0; b < BlockBytes; b++) begin
      mask[BlockW-1-8*b -: 8] = (in_data_i.valid_bytes > CntW'(b)) ? 8'hFF : 8'h00;
    end
  end

  assign in_ready_o       = !full_i;
  assign push_o           = in_valid_i && !full_i;
  assign push_item_o.data = raw & mask;
  assign push_item_o.last = in_data_i.final_block;

endmodule

`default_nettype wire

@@ rtl/ghash_queue.sv @@
// Small FIFO between front and back ends.
// Depth of at least 2; uses ghash_pkg for the item type.
`default_nettype none

module ghash_queue #(
  parameter int unsigned Depth = ghash_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ghash_pkg::q_item_t push_item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output ghash_pkg::q_item_t     pop_item_o
);
  import ghash_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntQW = $clog2(Depth + 1);

  q_item_t            mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == CntQW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ghash_back.sv @@
// Back end: accumulator fold and GF(2^128) multiply by H, digest register.
// Uses ghash_pkg for item types and the reduction constant.
`default_nettype none

module ghash_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [127:0]        key_i,
  input  wire logic                q_valid_i,
  input  wire ghash_pkg::q_item_t  q_item_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ghash_pkg::out_item_t     out_data_o,
  output ghash_pkg::back_status_t  status_o
);
  import ghash_pkg::*;

  // GCM multiply; bit 127 of a word is the x^0 coefficient.
  function automatic logic [BlockW-1:0] gf_mul(logic [BlockW-1:0] x, logic [BlockW-1:0] y);
    logic [BlockW-1:0]   a, b, r, z;
    logic [2*BlockW-2:0] c;
    logic [BlockW+5:0]   d;
    logic [7:0]          poly;
    for (int i = 0; i < BlockW; i++) begin
      a[i] = x[BlockW-1-i];
      b[i] = y[BlockW-1-i];
    end
    for (int p = 0; p < 8; p++) begin
      poly[p] = GfReduceHigh[HalfW-1-p];
    end
    c = '0;
    for (int i = 0; i < BlockW; i++) begin
      for (int j = 0; j < BlockW; j++) begin
        c[i+j] = c[i+j] ^ (a[i] & b[j]);
      end
    end
    d = {6'b0, c[BlockW-1:0]};
    for (int k = BlockW; k < 2*BlockW-1; k++) begin
      for (int p = 0; p < 8; p++) begin
        if (poly[p]) begin
          d[k-BlockW+p] = d[k-BlockW+p] ^ c[k];
        end
      end
    end
    r = d[BlockW-1:0];
    for (int k = BlockW; k < BlockW+6; k++) begin
      for (int p = 0; p < 8; p++) begin
        if (poly[p]) begin
          r[k-BlockW+p] = r[k-BlockW+p] ^ d[k];
        end
      end
    end
    for (int i = 0; i < BlockW; i++) begin
      z[BlockW-1-i] = r[i];
    end
    return z;
  endfunction

  logic [BlockW-1:0] acc_q, acc_d;
  logic [BlockW-1:0] prod;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = q_valid_i && (!q_item_i.last || out_free);
  assign prod     = gf_mul(acc_q ^ q_item_i.data, key_i);

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      if (q_item_i.last) begin
        acc_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        acc_d = prod;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.last) begin
      out_q <= '{digest_high: prod[BlockW-1:HalfW], digest_low: prod[HalfW-1:0]};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.pop_last = pop_o && q_item_i.last;
  assign status_o.acc_zero = (acc_q == '0);

endmodule

`default_nettype wire

@@ tb/ghash_gf128_accumulator_tb.sv @@
// Self-checking testbench for ghash_gf128_accumulator: random and directed
// message blocks, digests checked against a GF(2^128) GHASH predictor.
// Depends on ghash_pkg and the ghash_gf128_accumulator RTL.
`default_nettype none

module ghash_gf128_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ghash_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  ghash_gf128_accumulator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  in_item_t     pending_blocks[$];
  out_item_t    expected_digests[$];
  logic [127:0] ghash_acc = '0;
  logic [127:0] hash_key = '0;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic         in_fire = 1'b0;
  logic         hold_req = 1'b0;
  logic         hold_ack = 1'b0;
  int           hold_left = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Sender: a new transfer is offered only once the previous one went through.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (pending_blocks.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_data_i  <= pending_blocks.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Monitor: tracks key writes, predicts on each input transfer, checks outputs.
  always @(posedge clk_i) begin : monitor
    logic [127:0] mask;
    logic [127:0] sum;
    logic [127:0] prod;
    logic [127:0] v;
    out_item_t    exp_digest;
    int           n;
    int           b;
    int           i;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgKeyHigh: hash_key[127:64] = cfg_wdata_i;
          CfgKeyLow:  hash_key[63:0]   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        n = (in_data_i.valid_bytes > BlockBytes) ? BlockBytes : in_data_i.valid_bytes;
        mask = '0;
        for (b = 0; b < BlockBytes; b++) begin
          if (b < n) mask[127-8*b -: 8] = 8'hFF;
        end
        sum  = ghash_acc ^ ({in_data_i.block_high, in_data_i.block_low} & mask);
        prod = '0;
        v    = hash_key;
        for (i = 0; i < 128; i++) begin
          if (sum[127-i]) prod ^= v;
          if (v[0]) begin
            v = (v >> 1) ^ {GfReduceHigh, 64'h0};
          end else begin
            v = v >> 1;
          end
        end
        if (in_data_i.final_block) begin
          exp_digest.digest_high = prod[127:64];
          exp_digest.digest_low  = prod[63:0];
          expected_digests.push_back(exp_digest);
          ghash_acc = '0;
        end else begin
          ghash_acc = prod;
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_digests.size() == 0) begin
          $error("unexpected digest transfer: %h %h",
                 out_data_o.digest_high, out_data_o.digest_low);
          mismatches++;
        end else begin
          exp_digest = expected_digests.pop_front();
          if (out_data_o.digest_high !== exp_digest.digest_high) begin
            $error("digest_high: expected %h, actual %h",
                   exp_digest.digest_high, out_data_o.digest_high);
            mismatches++;
          end
          if (out_data_o.digest_low !== exp_digest.digest_low) begin
            $error("digest_low: expected %h, actual %h",
                   exp_digest.digest_low, out_data_o.digest_low);
            mismatches++;
          end
        end
      end
    end
    in_fire <= rst_ni && in_valid_i && in_ready_o;
  end

  function automatic logic [63:0] rand_half();
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_block(logic [63:0] hi, logic [63:0] lo, int vb, bit fin);
    in_item_t item;
    item.block_high  = hi;
    item.block_low   = lo;
    item.valid_bytes = CntW'(vb);
    item.final_block = fin;
    pending_blocks.push_back(item);
  endtask

  // Waits for every queued block to go through and every digest to arrive,
  // then waits further so a trailing non-final block has left the pipeline.
  task automatic settle();
    while (pending_blocks.size() != 0 || in_valid_i || expected_digests.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_key(cfg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed messages, some stray blocks with any count or flag.
  task automatic random_traffic(int n_blocks);
    int queued;
    int len;
    int k;
    queued = 0;
    while (queued < n_blocks) begin
      if ($urandom_range(99, 0) < 12) begin
        push_block(rand_half(), rand_half(), $urandom_range(31, 0), 1'($urandom_range(1, 0)));
        queued++;
      end else begin
        len = $urandom_range(6, 1);
        for (k = 0; k < len; k++) begin
          push_block(rand_half(), rand_half(),
                     (k == len - 1) ? $urandom_range(16, 1) : 16, k == len - 1);
        end
        queued += len;
      end
    end
  endtask

  initial begin
    int k;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Reset key is zero: any message hashes to zero.
    push_block('1, '1, 16, 1'b1);
    settle();

    // Identity key: the digest equals the masked block.
    write_key(CfgKeyHigh, 64'h8000_0000_0000_0000);
    write_key(CfgKeyLow, 64'h0);
    push_block('1, '1, 16, 1'b1);
    push_block('0, '0, 16, 1'b1);
    push_block('1, '1, 0, 1'b1);
    push_block('1, '1, 1, 1'b1);
    push_block('1, '1, 8, 1'b1);
    push_block('1, '1, 9, 1'b1);
    push_block('1, '1, 15, 1'b1);
    push_block('1, '1, 17, 1'b1);
    push_block('1, '1, 31, 1'b1);
    settle();

    // All-ones key, multi-block message and a zero-length block mid-message.
    write_key(CfgKeyHigh, '1);
    write_key(CfgKeyLow, '1);
    push_block('1, '1, 16, 1'b0);
    push_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 0, 1'b0);
    push_block(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 16, 1'b0);
    push_block(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 12, 1'b1);
    // Key change in the middle of a message.
    push_block(rand_half(), rand_half(), 16, 1'b0);
    push_block(rand_half(), rand_half(), 16, 1'b0);
    settle();
    write_key(CfgKeyHigh, {$urandom(), $urandom()});
    write_key(CfgKeyLow, {$urandom(), $urandom()});
    push_block(rand_half(), rand_half(), 5, 1'b1);
    settle();

    // No idling.
    random_traffic(190);
    settle();

    write_key(CfgKeyHigh, '1);
    write_key(CfgKeyLow, '1);
    send_idle_pct = 55;
    random_traffic(190);
    settle();

    // Receiver stalls; a long hold-off fills the pipeline with final blocks.
    write_key(CfgKeyHigh, '0);
    write_key(CfgKeyLow, {$urandom(), $urandom()});
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    hold_req = ~hold_req;
    for (k = 0; k < 40; k++) push_block(rand_half(), rand_half(), $urandom_range(16, 1), 1'b1);
    random_traffic(150);
    settle();

    write_key(CfgKeyHigh, {$urandom(), $urandom()});
    write_key(CfgKeyLow, {$urandom(), $urandom()});
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    random_traffic(190);
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
